### rtl/core/keyed_xor_cipher_crc_framer_assert.svh
// Assertion macros shared by the framer RTL.
`ifndef KEYED_XOR_CIPHER_CRC_FRAMER_ASSERT_SVH
`define KEYED_XOR_CIPHER_CRC_FRAMER_ASSERT_SVH

// cond must hold at every clock edge outside reset
`define KXCF_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define KXCF_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/kxcf_pkg.sv
// Shared types, constants and functions of the keyed XOR cipher CRC framer.
package kxcf_pkg;

  localparam int KEY_MAX             = 16;
  localparam int KEY_POS_W           = 4;
  localparam int KEY_LEN_W           = 5;
  localparam int BLOCK_BYTES_DEFAULT = 16;
  localparam int BLOCK_BYTES_MAX     = 64;
  localparam int CNT_W               = $clog2(BLOCK_BYTES_MAX - 4 + 1);
  localparam int CHECK_BYTES         = 4;
  localparam int QUEUE_DEPTH         = 4;
  localparam int QPTR_W              = $clog2(QUEUE_DEPTH);
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 64;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_FAILED   = 2'd3;

  localparam logic [1:0] KIND_ENC = 2'd0;
  localparam logic [1:0] KIND_ERR = 2'd1;
  localparam logic [1:0] KIND_REL = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             check;
    logic [31:0]      crc;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
    logic             bank;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } hold_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_done_t;

  localparam logic [7:0] KEY_TABLE [256] = '{
    8'h23, 8'hbe, 8'h84, 8'he1, 8'h6c, 8'hd6, 8'hae, 8'h52,
    8'h90, 8'h49, 8'hf1, 8'hf1, 8'hbb, 8'he9, 8'heb, 8'hb3,
    8'ha6, 8'hdb, 8'h3c, 8'h87, 8'h0c, 8'h3e, 8'h99, 8'h24,
    8'h5e, 8'h0d, 8'h1c, 8'h06, 8'hb7, 8'h47, 8'hde, 8'hb3,
    8'h12, 8'h4d, 8'hc8, 8'h43, 8'hbb, 8'h8b, 8'ha6, 8'h1f,
    8'h03, 8'h5a, 8'h7d, 8'h09, 8'h38, 8'h25, 8'h1f, 8'h5d,
    8'hd4, 8'hcb, 8'hfc, 8'h96, 8'hf5, 8'h45, 8'h3b, 8'h13,
    8'h0d, 8'h89, 8'h0a, 8'h1c, 8'hdb, 8'hae, 8'h32, 8'h20,
    8'h9a, 8'h50, 8'hee, 8'h40, 8'h78, 8'h36, 8'hfd, 8'h12,
    8'h49, 8'h32, 8'hf6, 8'h9e, 8'h7d, 8'h49, 8'hdc, 8'had,
    8'h4f, 8'h14, 8'hf2, 8'h44, 8'h40, 8'h66, 8'hd0, 8'h6b,
    8'hc4, 8'h30, 8'hb7, 8'h32, 8'h3b, 8'ha1, 8'h22, 8'hf6,
    8'h22, 8'h91, 8'h9d, 8'he1, 8'h8b, 8'h1f, 8'hda, 8'hb0,
    8'hca, 8'h99, 8'h02, 8'hb9, 8'h72, 8'h9d, 8'h49, 8'h2c,
    8'h80, 8'h7e, 8'hc5, 8'h99, 8'hd5, 8'he9, 8'h80, 8'hb2,
    8'hea, 8'hc9, 8'hcc, 8'h53, 8'hbf, 8'h67, 8'hd6, 8'hbf,
    8'h14, 8'hd6, 8'h7e, 8'h2d, 8'hdc, 8'h8e, 8'h66, 8'h83,
    8'hef, 8'h57, 8'h49, 8'h61, 8'hff, 8'h69, 8'h8f, 8'h61,
    8'hcd, 8'hd1, 8'h1e, 8'h9d, 8'h9c, 8'h16, 8'h72, 8'h72,
    8'he6, 8'h1d, 8'hf0, 8'h84, 8'h4f, 8'h4a, 8'h77, 8'h02,
    8'hd7, 8'he8, 8'h39, 8'h2c, 8'h53, 8'hcb, 8'hc9, 8'h12,
    8'h1e, 8'h33, 8'h74, 8'h9e, 8'h0c, 8'hf4, 8'hd5, 8'hd4,
    8'h9f, 8'hd4, 8'ha4, 8'h59, 8'h7e, 8'h35, 8'hcf, 8'h32,
    8'h22, 8'hf4, 8'hcc, 8'hcf, 8'hd3, 8'h90, 8'h2d, 8'h48,
    8'hd3, 8'h8f, 8'h75, 8'he6, 8'hd9, 8'h1d, 8'h2a, 8'he5,
    8'hc0, 8'hf7, 8'h2b, 8'h78, 8'h81, 8'h87, 8'h44, 8'h0e,
    8'h5f, 8'h50, 8'h00, 8'hd4, 8'h61, 8'h8d, 8'hbe, 8'h7b,
    8'h05, 8'h15, 8'h07, 8'h3b, 8'h33, 8'h82, 8'h1f, 8'h18,
    8'h70, 8'h92, 8'hda, 8'h64, 8'h54, 8'hce, 8'hb1, 8'h85,
    8'h3e, 8'h69, 8'h15, 8'hf8, 8'h46, 8'h6a, 8'h04, 8'h96,
    8'h73, 8'h0e, 8'hd9, 8'h16, 8'h2f, 8'h67, 8'h68, 8'hd4,
    8'hf7, 8'h4a, 8'h4a, 8'hd0, 8'h57, 8'h68, 8'h76, 8'h29
  };

  // finished CRC-32 (reflected, inverted in and out) extended by one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

### rtl/core/keyed_xor_cipher_crc_framer.sv
// Top level of the keyed XOR cipher with CRC-32 framing.
// The block takes one stream byte per cycle while in_stall is low and gives at most
// one result per cycle. Encrypt turns each byte into one ciphertext result and, at
// every block of BLOCK_BYTES-4 data bytes or at end of stream, four more check-byte
// results, so the single result port sets the sustained rate. Decrypt takes one
// byte per cycle while not stalled; deciphered data waits in a two-bank held-byte
// RAM until the block's CRC has been checked and is then released one byte per
// cycle while the output does not stall, and besides a full command queue and the
// key position fix-up below, the input stalls only while the bank it would fill
// still awaits release. A four-entry command queue lets input and output stall on
// their own. After a key_length write the input stalls while the key position is
// brought below the new length; when decrypting, the position is first rebuilt
// from the start of the current block, which can lengthen this stall.
module keyed_xor_cipher_crc_framer #(
  parameter int BLOCK_BYTES = kxcf_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [kxcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kxcf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_stream,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic                             is_check_byte,
  output logic [1:0]                       status,
  output logic                             run_last
);

  localparam int DATA_BYTES = BLOCK_BYTES - kxcf_pkg::CHECK_BYTES;
  localparam int IDX_W      = $clog2(DATA_BYTES);
  localparam int HOLD_DEPTH = 2 * (2 ** IDX_W);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  kxcf_pkg::entry_t    q_entry;
  kxcf_pkg::entry_t    q_head;
  kxcf_pkg::hold_wr_t  hold_wr;
  kxcf_pkg::rel_done_t rel_done;
  logic                ram_rd_en;
  logic [IDX_W:0]      ram_rd_addr;
  logic [7:0]          ram_q;

  kxcf_front #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (q_entry),
    .hold_wr       (hold_wr),
    .rel_done      (rel_done)
  );

  kxcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  kxcf_ram #(
    .WIDTH (8),
    .DEPTH (HOLD_DEPTH)
  ) u_hold (
    .clk     (clk),
    .wr_en   (hold_wr.en),
    .wr_addr ({hold_wr.bank, hold_wr.idx[IDX_W-1:0]}),
    .wr_data (hold_wr.data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  kxcf_back #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .rel_done      (rel_done),
    .ram_rd_en     (ram_rd_en),
    .ram_rd_addr   (ram_rd_addr),
    .ram_q         (ram_q),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_check_byte (is_check_byte),
    .status        (status),
    .run_last      (run_last)
  );

endmodule

### rtl/core/kxcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kxcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/kxcf_queue.sv
// Short command queue between the front and back ends.
`include "keyed_xor_cipher_crc_framer_assert.svh"

module kxcf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  kxcf_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output kxcf_pkg::entry_t head,
  output logic             empty
);

  kxcf_pkg::entry_t mem [kxcf_pkg::QUEUE_DEPTH];
  logic [kxcf_pkg::QPTR_W-1:0] wr_ptr;
  logic [kxcf_pkg::QPTR_W-1:0] rd_ptr;
  logic [kxcf_pkg::QPTR_W:0]   count;

  assign full  = (count == (kxcf_pkg::QPTR_W+1)'(kxcf_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `KXCF_ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full || pop, "queue push while full")
  `KXCF_ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty, "queue pop while empty")

endmodule

### rtl/core/kxcf_front.sv
// Front end: configuration, keystream, CRC, block framing and classification.
`include "keyed_xor_cipher_crc_framer_assert.svh"

module kxcf_front #(
  parameter int BLOCK_BYTES = kxcf_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [kxcf_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kxcf_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  input  logic                               end_of_stream,
  input  logic                               q_full,
  output logic                               q_push,
  output kxcf_pkg::entry_t                   q_entry,
  output kxcf_pkg::hold_wr_t                 hold_wr,
  input  kxcf_pkg::rel_done_t                rel_done
);

  localparam int DATA_BYTES = BLOCK_BYTES - kxcf_pkg::CHECK_BYTES;
  localparam int BC_W       = $clog2(BLOCK_BYTES + 1);
  localparam int PW         = kxcf_pkg::KEY_POS_W;
  localparam int LW         = kxcf_pkg::KEY_LEN_W;
  localparam int RAW_W      = $clog2(kxcf_pkg::KEY_MAX + DATA_BYTES);

  logic           direction;
  logic [63:0]    key_low;
  logic [63:0]    key_high;
  logic [LW-1:0]  key_length;
  logic [31:0]    crc;
  logic [RAW_W-1:0] key_pos;
  logic [PW-1:0]  key_base;
  logic [BC_W-1:0] bc;
  logic [31:0]    rcheck;
  logic           failed;
  logic [7:0]     dly [4];
  logic           bank;
  logic [1:0]     busy;

  logic [LW-1:0]  eff_len;
  logic [RAW_W-1:0] len_ext;
  logic [RAW_W-1:0] pos_plus;
  logic [RAW_W-1:0] pos_inc;
  logic [BC_W-1:0] data_done;
  logic           norm;
  logic           accept;
  logic [127:0]   key_all;
  logic [7:0]     key_char;
  logic [7:0]     xbyte;
  logic [31:0]    crc_upd;
  logic [31:0]    crc_next;
  logic [31:0]    rcheck_next;
  logic [BC_W-1:0] bc_inc;
  logic           data_slot;
  logic           enc_end;
  logic           dec_end;
  logic           short_blk;
  logic           mismatch;

  always_comb begin
    if (key_length == '0) begin
      eff_len = LW'(1);
    end else if (key_length > LW'(kxcf_pkg::KEY_MAX)) begin
      eff_len = LW'(kxcf_pkg::KEY_MAX);
    end else begin
      eff_len = key_length;
    end
  end

  assign len_ext  = RAW_W'(eff_len);
  assign norm     = (key_pos >= len_ext);
  assign in_stall = norm || q_full || (direction && busy[bank]);
  assign accept   = in_valid && !in_stall;

  assign key_all  = {key_high, key_low};
  assign key_char = key_all[key_pos[PW-1:0]*8 +: 8];
  assign xbyte    = in_byte ^ kxcf_pkg::KEY_TABLE[key_char];
  assign pos_plus = key_pos + RAW_W'(1);
  assign pos_inc  = (pos_plus == len_ext) ? '0 : pos_plus;

  // decrypt: data bytes of the current block already keyed from the block start
  assign data_done = data_slot ? bc : BC_W'(DATA_BYTES);

  // decrypt: a byte is confirmed as data once four more bytes of its block arrive
  assign crc_upd     = kxcf_pkg::crc_byte(crc, direction ? dly[3] : in_byte);
  assign crc_next    = (direction && (bc < BC_W'(4))) ? crc : crc_upd;
  assign rcheck_next = {in_byte, rcheck[31:8]};

  assign bc_inc    = bc + BC_W'(1);
  assign data_slot = (bc < BC_W'(DATA_BYTES));
  assign enc_end   = (bc_inc >= BC_W'(DATA_BYTES)) || end_of_stream;
  assign dec_end   = (bc_inc >= BC_W'(BLOCK_BYTES)) || end_of_stream;
  assign short_blk = (bc_inc <= BC_W'(kxcf_pkg::CHECK_BYTES));
  assign mismatch  = (crc_next != rcheck_next);

  always_comb begin
    q_entry = '0;
    q_push  = 1'b0;
    if (!direction) begin
      q_push        = accept;
      q_entry.kind  = kxcf_pkg::KIND_ENC;
      q_entry.data  = xbyte;
      q_entry.check = enc_end;
      q_entry.crc   = crc_next;
    end else begin
      q_push = accept && dec_end;
      if (failed) begin
        q_entry.kind   = kxcf_pkg::KIND_ERR;
        q_entry.status = kxcf_pkg::ST_FAILED;
      end else if (short_blk) begin
        q_entry.kind   = kxcf_pkg::KIND_ERR;
        q_entry.status = kxcf_pkg::ST_SHORT;
      end else if (mismatch) begin
        q_entry.kind   = kxcf_pkg::KIND_ERR;
        q_entry.status = kxcf_pkg::ST_MISMATCH;
      end else begin
        q_entry.kind   = kxcf_pkg::KIND_REL;
        q_entry.status = kxcf_pkg::ST_OK;
        q_entry.count  = kxcf_pkg::CNT_W'(bc_inc - BC_W'(kxcf_pkg::CHECK_BYTES));
        q_entry.bank   = bank;
      end
    end
  end

  always_comb begin
    hold_wr.en   = accept && direction && !failed && data_slot;
    hold_wr.bank = bank;
    hold_wr.idx  = kxcf_pkg::CNT_W'(bc);
    hold_wr.data = xbyte;
  end

  always_ff @(posedge clk) begin
    if (accept && direction) begin
      dly[0] <= xbyte;
      dly[1] <= dly[0];
      dly[2] <= dly[1];
      dly[3] <= dly[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction  <= 1'b0;
      key_low    <= '0;
      key_high   <= '0;
      key_length <= LW'(1);
      crc        <= '0;
      key_pos    <= '0;
      key_base   <= '0;
      bc         <= '0;
      rcheck     <= '0;
      failed     <= 1'b0;
      bank       <= 1'b0;
      busy       <= '0;
    end else begin
      if (rel_done.en) begin
        busy[rel_done.bank] <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          kxcf_pkg::REG_DIRECTION: begin
            direction <= cfg_data[0];
            crc       <= '0;
            key_pos   <= '0;
            key_base  <= '0;
            bc        <= '0;
            rcheck    <= '0;
            failed    <= 1'b0;
          end
          kxcf_pkg::REG_KEY_LOW:    key_low    <= cfg_data;
          kxcf_pkg::REG_KEY_HIGH:   key_high   <= cfg_data;
          kxcf_pkg::REG_KEY_LENGTH: begin
            key_length <= cfg_data[LW-1:0];
            // decrypt keys each byte from the block start under the new length
            if (direction) begin
              key_pos <= RAW_W'(key_base) + RAW_W'(data_done);
            end
          end
          default: ;
        endcase
      end else if (accept) begin
        crc <= crc_next;
        bc  <= bc_inc;
        if (!direction || data_slot) begin
          key_pos <= pos_inc;
        end
        if (!direction) begin
          if (enc_end) begin
            bc <= '0;
          end
        end else begin
          rcheck <= rcheck_next;
          if (dec_end) begin
            bc       <= '0;
            rcheck   <= '0;
            bank     <= ~bank;
            key_base <= key_pos[PW-1:0];
            if (!failed && (short_blk || mismatch)) begin
              failed <= 1'b1;
            end
            if (q_entry.kind == kxcf_pkg::KIND_REL) begin
              busy[bank] <= 1'b1;
            end
          end
        end
        if (end_of_stream) begin
          crc      <= '0;
          key_pos  <= '0;
          key_base <= '0;
          bc       <= '0;
          rcheck   <= '0;
          failed   <= 1'b0;
        end
      end else if (norm) begin
        key_pos <= key_pos - len_ext;
      end
    end
  end

  `KXCF_ASSERT_IMPLIES(a_pos_in_range, clk, rst, accept, key_pos < len_ext, "key position high")
  `KXCF_ASSERT_IMPLIES(a_bank_free, clk, rst, hold_wr.en, !busy[hold_wr.bank], "write to busy bank")

endmodule

### rtl/core/kxcf_back.sv
// Back end: expands queued commands into result transfers through an output register.
`include "keyed_xor_cipher_crc_framer_assert.svh"

module kxcf_back #(
  parameter int BLOCK_BYTES = kxcf_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  kxcf_pkg::entry_t            q_head,
  output logic                        q_pop,
  output kxcf_pkg::rel_done_t         rel_done,
  output logic                        ram_rd_en,
  output logic [$clog2(BLOCK_BYTES - kxcf_pkg::CHECK_BYTES):0] ram_rd_addr,
  input  logic [7:0]                  ram_q,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        is_check_byte,
  output logic [1:0]                  status,
  output logic                        run_last
);

  localparam int DATA_BYTES = BLOCK_BYTES - kxcf_pkg::CHECK_BYTES;
  localparam int IDX_W      = $clog2(DATA_BYTES);
  localparam int SUB_W      = (IDX_W > 3) ? IDX_W : 3;

  logic [SUB_W-1:0] sub;
  logic [7:0]       byte_r;
  logic             from_ram;

  logic             advance;
  logic             issue;
  logic [7:0]       s_byte;
  logic             s_chk;
  logic [1:0]       s_status;
  logic             s_ram;
  logic             s_last;
  logic [1:0]       cidx;
  logic [kxcf_pkg::CNT_W-1:0] cnt_m1;

  assign advance = !out_valid || !out_stall;
  assign issue   = advance && !q_empty;
  assign cidx    = 2'(sub - SUB_W'(1));
  assign cnt_m1  = q_head.count - kxcf_pkg::CNT_W'(1);

  always_comb begin
    s_byte   = '0;
    s_chk    = 1'b0;
    s_status = kxcf_pkg::ST_OK;
    s_ram    = 1'b0;
    s_last   = 1'b1;
    unique case (q_head.kind)
      kxcf_pkg::KIND_ENC: begin
        if (sub == '0) begin
          s_byte = q_head.data;
        end else begin
          s_byte = q_head.crc[cidx*8 +: 8];
          s_chk  = 1'b1;
        end
        s_last = !q_head.check || (sub == SUB_W'(kxcf_pkg::CHECK_BYTES));
      end
      kxcf_pkg::KIND_ERR: begin
        s_status = q_head.status;
      end
      kxcf_pkg::KIND_REL: begin
        s_ram  = 1'b1;
        s_last = (sub == SUB_W'(cnt_m1));
      end
      default: ;
    endcase
  end

  assign q_pop         = issue && s_last;
  assign rel_done.en   = q_pop && (q_head.kind == kxcf_pkg::KIND_REL);
  assign rel_done.bank = q_head.bank;
  assign ram_rd_en     = issue && s_ram;
  assign ram_rd_addr   = {q_head.bank, sub[IDX_W-1:0]};
  assign out_byte      = from_ram ? ram_q : byte_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      byte_r        <= s_byte;
      from_ram      <= s_ram;
      is_check_byte <= s_chk;
      status        <= s_status;
      run_last      <= s_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sub       <= '0;
    end else begin
      if (issue) begin
        out_valid <= 1'b1;
        sub       <= s_last ? '0 : sub + SUB_W'(1);
      end else if (advance) begin
        out_valid <= 1'b0;
      end
    end
  end

  `KXCF_ASSERT_IMPLIES(a_rel_count, clk, rst, issue && s_ram, q_head.count != '0, "empty release")
  `KXCF_ASSERT_ALWAYS(a_sub_range, clk, rst, sub < SUB_W'(DATA_BYTES) || sub <= SUB_W'(4), "step overrun")

endmodule
